// File: hdl/pdmf_pkg.sv
// Shared types, coefficient table and tap helpers for the PDM to PCM filter.
package pdmf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int BYTE_W     = 8;
  localparam int BIT_CNT_W  = 3;
  localparam int COEF_SLOTS = 64;
  localparam int COEF_IDX_W = 6;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // One PDM bit on its way into the cell chain.
  typedef struct packed {
    logic valid;
    logic pdm_bit;
    logic last;
  } pdmf_bit_t;

  // Blackman-windowed sinc, span 4, centre tap 3200.
  localparam sample_t COEF_TABLE [COEF_SLOTS] = '{
       16'sd0,    16'sd0,   -16'sd6,  -16'sd20,  -16'sd45,  -16'sd76,  -16'sd99,  -16'sd86,
       16'sd0,  16'sd197,  16'sd532, 16'sd1004, 16'sd1575, 16'sd2174, 16'sd2703, 16'sd3069,
    16'sd3200, 16'sd3069, 16'sd2703, 16'sd2174, 16'sd1575, 16'sd1004,  16'sd532,  16'sd197,
       16'sd0,  -16'sd86,  -16'sd99,  -16'sd76,  -16'sd45,  -16'sd20,   -16'sd6,    16'sd0,
       16'sd0,    16'sd0,    16'sd0,    16'sd0,    16'sd0,    16'sd0,    16'sd0,    16'sd0,
       16'sd0,    16'sd0,    16'sd0,    16'sd0,    16'sd0,    16'sd0,    16'sd0,    16'sd0,
       16'sd0,    16'sd0,    16'sd0,    16'sd0,    16'sd0,    16'sd0,    16'sd0,    16'sd0,
       16'sd0,    16'sd0,    16'sd0,    16'sd0,    16'sd0,    16'sd0,    16'sd0,    16'sd0
  };

  function automatic sample_t coef_at(input int idx);
    sample_t c;
    c = '0;
    if (idx >= 0 && idx < COEF_SLOTS) begin
      c = COEF_TABLE[idx[COEF_IDX_W-1:0]];
    end
    return c;
  endfunction

  // Partial sum held by cell k after reset: every history bit reads as 0.
  function automatic sample_t tail_init(input int k, input int taps);
    sample_t acc;
    int j;
    acc = '0;
    for (j = 0; j < taps; j++) begin
      if (j >= k) begin
        acc = acc - coef_at(j);
      end
    end
    return acc;
  endfunction

endpackage

// File: hdl/pdmf_serializer.sv
// Byte register that hands out PDM bits one per advance, LSB first.
module pdmf_serializer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [pdmf_pkg::BYTE_W-1:0]     s_tdata,
  input  logic                            advance,
  output pdmf_pkg::pdmf_bit_t             bit_out
);
  import pdmf_pkg::*;

  logic [BYTE_W-1:0]    byte_sr;
  logic [BIT_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 last_bit;
  logic                 take;

  assign last_bit = (cnt == {BIT_CNT_W{1'b1}});
  assign s_tready = !busy || (advance && last_bit);
  assign take     = s_tvalid && s_tready;

  assign bit_out.valid   = busy;
  assign bit_out.pdm_bit = byte_sr[0];
  assign bit_out.last    = last_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (take) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (advance) begin
      cnt <= cnt + 1'b1;
      if (last_bit) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_sr <= s_tdata;
    end else if (advance) begin
      byte_sr <= {1'b0, byte_sr[BYTE_W-1:1]};
    end
  end

endmodule

// File: hdl/pdmf_cell.sv
// One tap of the transposed FIR: adds or subtracts its coefficient.
module pdmf_cell #(
  parameter logic signed [15:0] COEF = 16'sd0,
  parameter logic signed [15:0] INIT = 16'sd0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                pdm_bit,
  input  pdmf_pkg::sample_t   sum_in,
  output pdmf_pkg::sample_t   sum_out
);
  import pdmf_pkg::*;

  sample_t sum_next;

  assign sum_next = pdm_bit ? sum_in + COEF : sum_in - COEF;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_out <= INIT;
    end else if (advance) begin
      sum_out <= sum_next;
    end
  end

endmodule

// File: hdl/pdm_to_pcm_fir.sv
// Top level of the PDM to PCM converter with a fixed windowed-sinc FIR.
//
// Input channel s_*: one item is a byte of eight PDM bits, bit 0 oldest
// in time (processed first). Output channel m_*: one item per PDM bit,
// a signed 16-bit PCM sample in m_tdata; m_tlast marks the eighth sample
// of each byte.
// The filter is a row of TAPS cells in transposed form. Each PDM bit
// moves the whole row one step; cell 0 is the output register itself.
// An accepted byte is first held in the serializer register; each of its
// samples is then registered in cell 0. Throughput: one sample per cycle
// while m_tready does not stall the row; the next byte is taken in the cycle
// its predecessor's last bit enters the row, so bytes stream with no gap.
// Stall: while m_tready is low and a sample waits, the row and the bit
// serializer hold; s_tready drops once the current byte is pending.
// Reset: history reads as all zero bits, so the cells load the partial
// sums of an all-zero history; no items are pending on either side.
module pdm_to_pcm_fir #(
  parameter int TAPS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] pdm_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] pcm_sample
  output logic        m_tlast    // last_of_byte
);
  import pdmf_pkg::*;

  pdmf_bit_t bit_cur;
  logic      advance;
  sample_t   sums [TAPS+1];

  assign advance = bit_cur.valid && (!m_tvalid || m_tready);

  pdmf_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .advance  (advance),
    .bit_out  (bit_cur)
  );

  assign sums[TAPS] = '0;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    pdmf_cell #(
      .COEF (coef_at(k)),
      .INIT (tail_init(k, TAPS))
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .pdm_bit (bit_cur.pdm_bit),
      .sum_in  (sums[k+1]),
      .sum_out (sums[k])
    );
  end

  assign m_tdata = sums[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
      m_tlast  <= bit_cur.last;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the PDM to PCM FIR filter.
`timescale 1ns / 1ps

module testbench;
  import pdmf_pkg::*;

  localparam int NUM_TAPS   = 32;
  localparam int RAND_ITEMS = 209;
  localparam int DRAIN_CYC  = 20;
  localparam longint TIMEOUT_NS = 5_000_000;

  localparam int FIR_COEF [NUM_TAPS] = '{
       0,    0,   -6,  -20,  -45,  -76,  -99,  -86,
       0,  197,  532, 1004, 1575, 2174, 2703, 3069,
    3200, 3069, 2703, 2174, 1575, 1004,  532,  197,
       0,  -86,  -99,  -76,  -45,  -20,   -6,    0
  };

  typedef struct {
    sample_t pcm;
    logic    last;
  } pcm_item_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tlast;

  pcm_item_t   pcm_expected [$];
  logic [31:0] pdm_history;
  int          fail_count;
  bit          no_idle;
  int          sd_acc;

  pdm_to_pcm_fir u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // Signed sum of +coef for set history bits and -coef for clear ones, mod 2^16.
  function automatic sample_t fir_sum(input logic [31:0] hist);
    logic [15:0] acc;
    acc = '0;
    for (int i = 0; i < NUM_TAPS; i++) begin
      if (hist[i]) begin
        acc = acc + 16'(FIR_COEF[i]);
      end else begin
        acc = acc - 16'(FIR_COEF[i]);
      end
    end
    return sample_t'(acc);
  endfunction

  task automatic predict_byte(input logic [7:0] pdm_byte);
    pcm_item_t exp_item;
    for (int k = 0; k < 8; k++) begin
      pdm_history   = {pdm_history[30:0], pdm_byte[k]};
      exp_item.pcm  = fir_sum(pdm_history);
      exp_item.last = (k == 7);
      pcm_expected.push_back(exp_item);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // First-order sigma-delta: density of ones tracks level/256.
  function automatic logic [7:0] sigma_delta_byte(input int level);
    logic [7:0] b;
    for (int k = 0; k < 8; k++) begin
      sd_acc = sd_acc + level;
      if (sd_acc >= 256) begin
        b[k]   = 1'b1;
        sd_acc = sd_acc - 256;
      end else begin
        b[k] = 1'b0;
      end
    end
    return b;
  endfunction

  task automatic send_pdm_byte(input logic [7:0] pdm_byte);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= pdm_byte;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_byte(pdm_byte);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Output-side backpressure: mostly short stalls, some long, some long ready runs.
  initial begin
    int hi_len;
    int lo_len;
    int r;
    m_tready = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      hi_len = (r < 15) ? $urandom_range(50, 120) : $urandom_range(1, 12);
      r = $urandom_range(0, 99);
      lo_len = (r < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      m_tready <= 1'b1;
      repeat (hi_len) @(negedge clk);
      m_tready <= 1'b0;
      repeat (lo_len) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    pcm_item_t exp_item;
    if (!rst && m_tvalid && m_tready) begin
      if (pcm_expected.size() == 0) begin
        $error("unexpected pcm item: pcm_sample=%0d last_of_byte=%0b",
               $signed(m_tdata), m_tlast);
        fail_count++;
      end else begin
        exp_item = pcm_expected.pop_front();
        if (sample_t'(m_tdata) !== exp_item.pcm) begin
          $error("pcm_sample: expected %0d, actual %0d", exp_item.pcm, $signed(m_tdata));
          fail_count++;
        end
        if (m_tlast !== exp_item.last) begin
          $error("last_of_byte: expected %0b, actual %0b", exp_item.last, m_tlast);
          fail_count++;
        end
      end
    end
  end

  // Zero history right after reset: early samples subtract every tap.
  task automatic test_after_reset();
    send_pdm_byte(8'h00);
    send_pdm_byte(8'h01);
    send_pdm_byte(8'h00);
  endtask

  // All-ones and all-zeros histories give plus and minus the sum of all taps.
  task automatic test_extremes();
    repeat (4) send_pdm_byte(8'hFF);
    send_pdm_byte(8'h7F);
    repeat (4) send_pdm_byte(8'h00);
    send_pdm_byte(8'h80);
  endtask

  task automatic test_bit_order();
    send_pdm_byte(8'h01);
    send_pdm_byte(8'h80);
    send_pdm_byte(8'hAA);
    send_pdm_byte(8'h55);
    send_pdm_byte(8'h0F);
    send_pdm_byte(8'hF0);
    send_pdm_byte(8'hCC);
    send_pdm_byte(8'h33);
  endtask

  task automatic test_random();
    int level;
    int r;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 30 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
        level   = $urandom_range(0, 256);
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
        send_pdm_byte(sigma_delta_byte(level));
      end else if (r < 90) begin
        send_pdm_byte(8'($urandom_range(0, 255)));
      end else if (r < 95) begin
        send_pdm_byte(8'hFF);
      end else begin
        send_pdm_byte(8'h00);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    pdm_history = '0;
    fail_count  = 0;
    no_idle     = 1'b0;
    sd_acc      = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_after_reset();
    test_extremes();
    test_bit_order();
    test_random();
    s_tvalid <= 1'b0;

    while (pcm_expected.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/pdmf_pkg.sv
hdl/pdmf_serializer.sv
hdl/pdmf_cell.sv
hdl/pdm_to_pcm_fir.sv
sim/testbench.sv
